### rtl/ps2m_pkg.sv
// PS/2 mouse cursor tracker: shared widths, constants and register indexes.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ps2m_pkg;

    localparam int POS_W  = 12;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 12;

    localparam int SYNC_BIT    = 3;
    localparam int EDGE_MARGIN = 10;

    localparam logic [POS_W-1:0] POS_X_RESET  = POS_W'(400);
    localparam logic [POS_W-1:0] POS_Y_RESET  = POS_W'(300);
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(768);

    typedef enum logic {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

### rtl/ps2m_byte_if.sv
// Input channel: one controller byte with its auxiliary-port flag per word.
// Depends on ps2m_pkg.
`timescale 1ns / 1ps

interface ps2m_byte_if
    import ps2m_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

### rtl/ps2m_cur_if.sv
// Output channel: cursor position, button levels and press edges per word.
// Depends on ps2m_pkg.
`timescale 1ns / 1ps

interface ps2m_cur_if
    import ps2m_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] ptr_col;
    logic [POS_W-1:0] ptr_row;
    logic             left_down;
    logic             right_down;
    logic             left_pressed;
    logic             right_pressed;

    modport source (
        output valid, output ptr_col, output ptr_row, output left_down,
        output right_down, output left_pressed, output right_pressed, input ready
    );
    modport sink (
        input valid, input ptr_col, input ptr_row, input left_down,
        input right_down, input left_pressed, input right_pressed, output ready
    );
endinterface

### rtl/ps2_mouse_cursor_tracker_unit.sv
// PS/2 mouse cursor tracker top level: packet framing, cursor update, clamp.
// Depends on ps2m_pkg, ps2m_byte_if and ps2m_cur_if.
`timescale 1ns / 1ps
//
// Usage:
//   i_byte takes one controller byte per word with its auxiliary-port flag.
//   Keyboard bytes and first bytes with the sync bit clear are swallowed.
//   Every third mouse byte completes a packet and yields one word on o_cur:
//   the clamped cursor position, the button levels and the press edges.
//   Config port: i_cfg_we writes i_cfg_data to screen width (index 0) or
//   screen height (index 1); write only while the block is idle.
// Timing:
//   One byte per cycle unless o_cur stalls. A completing byte is presented
//   on o_cur the cycle after it is accepted, from a single result register;
//   the framing state, cursor and button history update at the accepting edge.
// Stall:
//   While a result waits and o_cur.ready is low, i_byte.ready is low; when
//   o_cur.ready is high a new byte is taken in the same cycle the held word
//   leaves. Keyboard and framing bytes are also held off during a stall.
// Reset:
//   Synchronous, active low. Cursor returns to 400,300, framing restarts,
//   button history clears, screen size returns to 1024 x 768.
//
module ps2_mouse_cursor_tracker_unit
    import ps2m_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    ps2m_byte_if.sink          i_byte,
    ps2m_cur_if.source         o_cur,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        ST_BYTE0,
        ST_BYTE1,
        ST_BYTE2
    } t_state;

    t_state              r_state, n_state;
    logic [BYTE_W-1:0]   r_pkt0, n_pkt0;
    logic [BYTE_W-1:0]   r_pkt1, n_pkt1;
    logic [POS_W-1:0]    r_pos_x, n_pos_x;
    logic [POS_W-1:0]    r_pos_y, n_pos_y;
    logic                r_prev_left, n_prev_left;
    logic                r_prev_right, n_prev_right;
    logic [CFG_W-1:0]    r_width, r_height;

    logic                r_out_valid, n_out_valid;
    logic [POS_W-1:0]    r_ptr_col, n_ptr_col;
    logic [POS_W-1:0]    r_ptr_row, n_ptr_row;
    logic                r_left_down, n_left_down;
    logic                r_right_down, n_right_down;
    logic                r_left_pressed, n_left_pressed;
    logic                r_right_pressed, n_right_pressed;

    logic                accept;
    logic                left, right;
    logic signed [POS_W+1:0] sum_x, sum_y;

    function automatic logic [POS_W-1:0] clamp_pos(
        input logic signed [POS_W+1:0] p,
        input logic [CFG_W-1:0]        size
    );
        logic [POS_W-1:0] lim;
        lim = (size < CFG_W'(EDGE_MARGIN)) ? '0 : POS_W'(size - CFG_W'(EDGE_MARGIN));
        if (p < 0)
            return '0;
        else if (p > $signed({2'b00, lim}))
            return lim;
        else
            return p[POS_W-1:0];
    endfunction

    assign i_byte.ready = i_rst_n && (!r_out_valid || o_cur.ready);
    assign accept       = i_byte.valid && i_byte.ready;

    assign left  = r_pkt0[0];
    assign right = r_pkt0[1];
    assign sum_x = $signed({2'b00, r_pos_x})
                 + $signed({{(POS_W+2-BYTE_W){r_pkt1[BYTE_W-1]}}, r_pkt1});
    assign sum_y = $signed({2'b00, r_pos_y})
                 - $signed({{(POS_W+2-BYTE_W){i_byte.data_byte[BYTE_W-1]}},
                            i_byte.data_byte});

    always_comb begin
        n_state         = r_state;
        n_pkt0          = r_pkt0;
        n_pkt1          = r_pkt1;
        n_pos_x         = r_pos_x;
        n_pos_y         = r_pos_y;
        n_prev_left     = r_prev_left;
        n_prev_right    = r_prev_right;
        n_out_valid     = r_out_valid && !o_cur.ready;
        n_ptr_col       = r_ptr_col;
        n_ptr_row       = r_ptr_row;
        n_left_down     = r_left_down;
        n_right_down    = r_right_down;
        n_left_pressed  = r_left_pressed;
        n_right_pressed = r_right_pressed;
        if (accept && i_byte.from_aux) begin
            case (r_state)
                ST_BYTE0: begin
                    if (i_byte.data_byte[SYNC_BIT]) begin
                        n_pkt0  = i_byte.data_byte;
                        n_state = ST_BYTE1;
                    end
                end
                ST_BYTE1: begin
                    n_pkt1  = i_byte.data_byte;
                    n_state = ST_BYTE2;
                end
                default: begin
                    n_state         = ST_BYTE0;
                    n_pos_x         = clamp_pos(sum_x, r_width);
                    n_pos_y         = clamp_pos(sum_y, r_height);
                    n_prev_left     = left;
                    n_prev_right    = right;
                    n_out_valid     = 1'b1;
                    n_ptr_col       = n_pos_x;
                    n_ptr_row       = n_pos_y;
                    n_left_down     = left;
                    n_right_down    = right;
                    n_left_pressed  = left && !r_prev_left;
                    n_right_pressed = right && !r_prev_right;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_BYTE0;
            r_pos_x      <= POS_X_RESET;
            r_pos_y      <= POS_Y_RESET;
            r_prev_left  <= 1'b0;
            r_prev_right <= 1'b0;
            r_out_valid  <= 1'b0;
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
        end else begin
            r_state      <= n_state;
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_prev_left  <= n_prev_left;
            r_prev_right <= n_prev_right;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_pkt0          <= n_pkt0;
        r_pkt1          <= n_pkt1;
        r_ptr_col       <= n_ptr_col;
        r_ptr_row       <= n_ptr_row;
        r_left_down     <= n_left_down;
        r_right_down    <= n_right_down;
        r_left_pressed  <= n_left_pressed;
        r_right_pressed <= n_right_pressed;
    end

    assign o_cur.valid         = r_out_valid;
    assign o_cur.ptr_col       = r_ptr_col;
    assign o_cur.ptr_row       = r_ptr_row;
    assign o_cur.left_down     = r_left_down;
    assign o_cur.right_down    = r_right_down;
    assign o_cur.left_pressed  = r_left_pressed;
    assign o_cur.right_pressed = r_right_pressed;

    // third mouse byte always leaves a word behind
    a_pkt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte.from_aux && r_state == ST_BYTE2) |=> r_out_valid)
        else $error("completed packet produced no word");

    // keyboard bytes leave framing and cursor untouched
    a_kbd_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_byte.from_aux) |=>
            ($stable(r_state) && $stable(r_pos_x) && $stable(r_pos_y)))
        else $error("keyboard byte altered mouse state");

    // a press edge implies the button is down
    a_press_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((!r_left_pressed || r_left_down)
                      && (!r_right_pressed || r_right_down)))
        else $error("press edge without button level");

endmodule
